FILE: rtl/tick_task_scheduler_defines.svh
// assertion macros for the tick task scheduler
`ifndef TICK_TASK_SCHEDULER_DEFINES_SVH
`define TICK_TASK_SCHEDULER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the tick task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_ADD_OK   = 2'd0,
    KIND_ADD_FULL = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_TICK_END = 2'd3
  } kind_t;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // one command between front and back
  typedef struct packed {
    logic        is_tick;
    logic [31:0] due_tick;
    logic [31:0] repeat_interval;
    logic        is_periodic;
    logic [7:0]  task_tag;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [7:0]  fired_tag;
    logic [31:0] tick_value;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

FILE: rtl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// Accepts input transactions and queues them as commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tts_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_operation,
  input  wire logic [31:0]   in_due_tick,
  input  wire logic [31:0]   in_repeat_interval,
  input  wire logic          in_is_periodic,
  input  wire logic [7:0]    in_task_tag,
  output logic               cmd_valid,
  output tts_pkg::cmd_t      cmd,
  input  wire logic          cmd_take
);
  localparam int PW = $clog2(tts_pkg::CMDQ_DEPTH);
  tts_pkg::cmd_t q_r [tts_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push_ok;
  tts_pkg::cmd_t new_cmd;

  assign in_full   = (cnt_r == (PW+1)'(tts_pkg::CMDQ_DEPTH));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    new_cmd.is_tick         = (in_operation == tts_pkg::OP_TICK);
    new_cmd.due_tick        = in_due_tick;
    new_cmd.repeat_interval = in_repeat_interval;
    new_cmd.is_periodic     = in_is_periodic;
    new_cmd.task_tag        = in_task_tag;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= new_cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) begin
        wp_r <= wp_r + 1'b1;
      end
      if (cmd_take) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push_ok) - (PW+1)'(cmd_take);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// Holds the task table and tick counter; runs adds and slot-by-slot tick scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tts_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire tts_pkg::cmd_t cmd,
  output logic               cmd_take,
  output logic               res_valid,
  output tts_pkg::res_t      res,
  input  wire logic          res_take
);
  localparam int N  = tts_pkg::NUM_SLOTS;
  localparam int SW = tts_pkg::SLOT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_END} state_t;

  state_t         state_r;
  logic [N-1:0]   valid_r;
  logic [31:0]    due_r  [N];
  logic [31:0]    ivl_r  [N];
  logic           per_r  [N];
  logic [7:0]     tag_r  [N];
  logic [31:0]    tick_r;
  logic [SW-1:0]  idx_r;
  logic           res_valid_r;
  tts_pkg::res_t  res_r;

  logic           free_any;
  logic [SW-1:0]  free_idx;
  logic           out_room;
  logic           hit;
  logic           res_load;
  logic           res_valid_nxt;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign out_room  = !res_valid_r || res_take;
  assign hit       = valid_r[idx_r] && (due_r[idx_r] == tick_r);
  assign cmd_take  = (state_r == ST_IDLE) && cmd_valid && out_room;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // a new result enters the output register
  assign res_load      = (cmd_take && !cmd.is_tick) ||
                         ((state_r == ST_SCAN) && hit && out_room) ||
                         ((state_r == ST_END) && out_room);
  assign res_valid_nxt = res_load || (res_valid_r && !res_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      tick_r      <= '0;
      idx_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (cmd_take) begin
            if (cmd.is_tick) begin
              state_r <= ST_SCAN;
              idx_r   <= '0;
            end else begin
              res_r.fired_tag  <= cmd.task_tag;
              res_r.tick_value <= tick_r;
              res_r.last       <= 1'b1;
              if (free_any) begin
                valid_r[free_idx] <= 1'b1;
                due_r[free_idx]   <= cmd.due_tick;
                ivl_r[free_idx]   <= cmd.repeat_interval;
                per_r[free_idx]   <= cmd.is_periodic;
                tag_r[free_idx]   <= cmd.task_tag;
                res_r.kind        <= tts_pkg::KIND_ADD_OK;
                res_r.slot        <= 4'(free_idx);
              end else begin
                res_r.kind <= tts_pkg::KIND_ADD_FULL;
                res_r.slot <= '0;
              end
            end
          end
        end
        ST_SCAN: begin
          if (!hit || out_room) begin
            if (hit) begin
              res_r.kind       <= tts_pkg::KIND_FIRED;
              res_r.slot       <= 4'(idx_r);
              res_r.fired_tag  <= tag_r[idx_r];
              res_r.tick_value <= tick_r;
              res_r.last       <= 1'b0;
              if (per_r[idx_r]) begin
                due_r[idx_r] <= due_r[idx_r] + ivl_r[idx_r];
              end else begin
                valid_r[idx_r] <= 1'b0;
              end
            end
            if (idx_r == SW'(N - 1)) begin
              state_r <= ST_END;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        ST_END: begin
          if (out_room) begin
            res_r.kind       <= tts_pkg::KIND_TICK_END;
            res_r.slot       <= '0;
            res_r.fired_tag  <= '0;
            res_r.tick_value <= tick_r;
            res_r.last       <= 1'b1;
            tick_r           <= tick_r + 32'd1;
            state_r          <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tick_task_scheduler.sv
// ----------------------------------------------------------------------------
// tick_task_scheduler
// Timer task table of sixteen slots driven by a 32-bit tick counter.
// ----------------------------------------------------------------------------
// An add transaction yields a single result. A tick transaction walks the
// slots one per cycle, pausing whenever a result waits for room at the
// output, and closes with a tick-end result. A two-entry command queue in
// front keeps accepting pushes while a scan runs, until it is full.
`timescale 1ns / 1ps
`default_nettype none
module tick_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_due_tick,
  input  wire logic [31:0] in_repeat_interval,
  input  wire logic        in_is_periodic,
  input  wire logic [7:0]  in_task_tag,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_slot,
  output logic [7:0]       out_fired_tag,
  output logic [31:0]      out_tick_value,
  output logic             out_last
);
  logic          cmd_valid, cmd_take, res_valid;
  tts_pkg::cmd_t cmd;
  tts_pkg::res_t res;

  tts_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_operation, .in_due_tick,
    .in_repeat_interval, .in_is_periodic, .in_task_tag, .cmd_valid, .cmd, .cmd_take
  );

  tts_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .res_valid, .res,
    .res_take(pop && res_valid)
  );

  assign empty          = !res_valid;
  assign out_kind       = res.kind;
  assign out_slot       = res.slot;
  assign out_fired_tag  = res.fired_tag;
  assign out_tick_value = res.tick_value;
  assign out_last       = res.last;
endmodule
`default_nettype wire

FILE: rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the tick task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tick_task_scheduler_defines.svh"
module tts_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  out_kind,
  input wire logic [3:0]  out_slot,
  input wire logic [7:0]  out_fired_tag,
  input wire logic        out_last
);
  `TTS_ASSERT_IMP(a_last_kind, clk, rst_n, !empty, out_last == (out_kind != tts_pkg::KIND_FIRED))
  `TTS_ASSERT_IMP(a_end_zero, clk, rst_n, !empty && out_kind == tts_pkg::KIND_TICK_END, out_slot == 4'd0 && out_fired_tag == 8'd0)
  `TTS_ASSERT_IMP(a_full_slot, clk, rst_n, !empty && out_kind == tts_pkg::KIND_ADD_FULL, out_slot == 4'd0)
  `TTS_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_kind) && $stable(out_slot))
endmodule
bind tick_task_scheduler tts_checker u_tts_checker (
  .clk, .rst_n, .empty, .pop, .out_kind, .out_slot, .out_fired_tag, .out_last
);
`default_nettype wire
